// ----- rtl/core/itrt_pkg.sv -----
// Shared constants, types and the digit-to-ASCII function of the
// integer-to-radix-text formatter. No dependencies.
`timescale 1ns / 1ps

package itrt_pkg;

  // Field widths of the command and result ports
  localparam int VALUE_IN_W = 32;
  localparam int RADIX_W    = 6;
  localparam int SPEC_W     = 7;
  localparam int FLAGS_W    = 7;
  localparam int ROOM_W     = 7;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 7;

  // Sizing
  localparam int VALUE_BITS = 32;
  localparam int MAX_OUT    = 64;
  localparam int MAX_RADIX  = 36;
  localparam int MIN_RADIX  = 2;

  // Internal character counts (field width plus sign, prefix and precision)
  localparam int COUNT_W = 8;
  localparam int REST_W  = COUNT_W + 1;

  // Digit stack
  localparam int DIG_DEPTH = VALUE_BITS;
  localparam int ND_W      = $clog2(DIG_DEPTH + 1);

  // Divider: DIV_STEP quotient bits per cycle
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Format flag bits
  localparam int FLAG_ZERO   = 0;
  localparam int FLAG_SIGNED = 1;
  localparam int FLAG_PLUS   = 2;
  localparam int FLAG_SPACE  = 3;
  localparam int FLAG_LEFT   = 4;
  localparam int FLAG_PREFIX = 5;
  localparam int FLAG_UPPER  = 6;

  // Radix values that carry a prefix
  localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [RADIX_W-1:0] digit;
  } stack_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base_ch;
    base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < RADIX_W'(10)) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return base_ch + CHAR_W'(d - RADIX_W'(10));
  endfunction

endpackage

// ----- rtl/core/itrt_divider.sv -----
// Iterative restoring divider: DIV_STEP quotient bits per cycle, a narrow
// divisor (the radix). Depends on itrt_pkg.
`timescale 1ns / 1ps

module itrt_divider import itrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [RADIX_W-1:0]    remainder_o
);

  logic [DIV_W-1:0]     work_q, work_d;
  logic [RADIX_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic                 cnt_last;

  assign cnt_last = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

  always_comb begin : div_step
    logic [RADIX_W:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_d, work_d[DIV_W-1]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = RADIX_W'(trial - {1'b0, dsr_q});
        work_d = {work_d[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[RADIX_W-1:0];
        work_d = {work_d[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && cnt_last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= DIV_W'(dividend_i);
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

// ----- rtl/core/itrt_digit_stack.sv -----
// Digit stack: a shift line that takes digits least significant first and
// gives them back most significant first. Depends on itrt_pkg.
`timescale 1ns / 1ps

module itrt_digit_stack import itrt_pkg::*; (
  input  logic               clk_i,
  input  stack_ctrl_t        ctrl_i,
  output logic [RADIX_W-1:0] top_o
);

  logic [RADIX_W-1:0] slot_q [DIG_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      slot_q[0] <= ctrl_i.digit;
      for (int i = 1; i < DIG_DEPTH; i++) begin
        slot_q[i] <= slot_q[i-1];
      end
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < DIG_DEPTH - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  assign top_o = slot_q[0];

endmodule

// ----- rtl/core/integer_to_radix_text.sv -----
// Top level of the printf-style integer formatter: sequencer, sizing and
// character emission. Depends on itrt_pkg, itrt_divider, itrt_digit_stack.
`timescale 1ns / 1ps

// Usage
//   Command: drive value_i, radix_i, field_width_i, min_digits_i,
//   format_flags_i and room_i and raise start; the item is taken at a
//   clock edge where start is high and busy is low. busy stays high
//   until the last character of the item has been issued.
//   Results: one character per strobe_o cycle, in text order; last_o
//   marks the final one, which carries the character count on length_o.
//   A bad radix or zero room gives a single strobe with char_present_o
//   low, last_o high and length_o zero.
//   Timing: digits come from the shared divider, one per division
//   (nd digits). Then the sizing states S_SIZE1 and S_SIZE2, then one
//   character per cycle. The next item may be taken in the cycle in
//   which the last strobe shows. A rejected item skips the divider and
//   gives its strobe from the S_EMPTY state.
//   Reset: asynchronous, active low; the block comes up idle.
//   The receiver cannot stall: each strobe lasts exactly one cycle.

module integer_to_radix_text import itrt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [VALUE_IN_W-1:0]    value_i,
  input  logic [RADIX_W-1:0]       radix_i,
  input  logic signed [SPEC_W-1:0] field_width_i,
  input  logic signed [SPEC_W-1:0] min_digits_i,
  input  logic [FLAGS_W-1:0]       format_flags_i,
  input  logic [ROOM_W-1:0]        room_i,
  output logic                     strobe_o,
  output logic [CHAR_W-1:0]        character_o,
  output logic                     char_present_o,
  output logic                     last_o,
  output logic [LEN_W-1:0]         length_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SIZE1 = 3'd2;
  localparam logic [2:0] S_SIZE2 = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0] state_q, state_d;

  // Item fields
  logic signed [SPEC_W-1:0] width_q;
  logic signed [SPEC_W-1:0] prec_q;
  logic [RADIX_W-1:0]       radix_q;
  logic [ROOM_W-1:0]        cap_q;
  logic                     upper_q, zero_q, left_q;
  logic                     sign_on_q;
  logic [CHAR_W-1:0]        sign_ch_q;
  logic [1:0]               pfx_len_q;

  // Sizing
  logic [ND_W-1:0]    nd_q, nd_d;
  logic [COUNT_W-1:0] prec_eff_q, prec_eff_d;
  logic [REST_W-1:0]  rest_q, rest_d;
  logic [COUNT_W-1:0] b_lead_q, b_sign_q, b_pfx_q, b_prec_q, b_dig_q, out_len_q;
  logic [COUNT_W-1:0] b_lead_d, b_sign_d, b_pfx_d, b_prec_d, b_dig_d, out_len_d;
  logic [COUNT_W-1:0] pos_q, pos_d;

  // Result register
  logic              strobe_q, strobe_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              present_q, present_d;
  logic              last_q, last_d;
  logic [LEN_W-1:0]  len_q, len_d;

  // Accept-cycle decode
  logic                  accept;
  logic [FLAGS_W-1:0]    flags_in;
  logic [VALUE_BITS-1:0] mag_raw, mag_in;
  logic                  neg_in;
  logic [ROOM_W-1:0]     cap_in;
  logic                  item_ok;
  logic                  sign_on_in;
  logic [CHAR_W-1:0]     sign_ch_in;
  logic [1:0]            pfx_len_in;

  // Divider and stack
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;
  stack_ctrl_t           stack_ctrl;
  logic [RADIX_W-1:0]    stack_top;

  // Sizing helpers
  logic [COUNT_W-1:0] prec_u, nd_u, pad, total;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    flags_in = format_flags_i;
    if (flags_in[FLAG_LEFT]) begin
      flags_in[FLAG_ZERO] = 1'b0;
    end
    mag_raw = value_i[VALUE_BITS-1:0];
    neg_in  = flags_in[FLAG_SIGNED] && mag_raw[VALUE_BITS-1];
    mag_in  = neg_in ? VALUE_BITS'(~mag_raw + VALUE_BITS'(1)) : mag_raw;
    cap_in  = (room_i > ROOM_W'(MAX_OUT)) ? ROOM_W'(MAX_OUT) : room_i;
    item_ok = (radix_i >= RADIX_W'(MIN_RADIX)) && (radix_i <= RADIX_W'(MAX_RADIX)) &&
              (cap_in != '0);
    sign_on_in = 1'b1;
    sign_ch_in = CH_MINUS;
    if (!neg_in) begin
      if (flags_in[FLAG_SIGNED] && flags_in[FLAG_PLUS]) begin
        sign_ch_in = CH_PLUS;
      end else if (flags_in[FLAG_SIGNED] && flags_in[FLAG_SPACE]) begin
        sign_ch_in = CH_SPACE;
      end else begin
        sign_on_in = 1'b0;
      end
    end
    pfx_len_in = 2'd0;
    if (flags_in[FLAG_PREFIX]) begin
      if (radix_i == RADIX_HEX) begin
        pfx_len_in = 2'd2;
      end else if (radix_i == RADIX_OCT) begin
        pfx_len_in = 2'd1;
      end
    end
  end

  itrt_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  itrt_digit_stack u_stack (
    .clk_i  (clk_i),
    .ctrl_i (stack_ctrl),
    .top_o  (stack_top)
  );

  assign prec_u = prec_q[SPEC_W-1] ? '0 : COUNT_W'(prec_q[SPEC_W-2:0]);
  assign nd_u   = COUNT_W'(nd_q);
  assign pad    = (rest_q[REST_W-1] || rest_q == '0) ? '0 : rest_q[COUNT_W-1:0];

  always_comb begin
    state_d      = state_q;
    nd_d         = nd_q;
    prec_eff_d   = prec_eff_q;
    rest_d       = rest_q;
    b_lead_d     = b_lead_q;
    b_sign_d     = b_sign_q;
    b_pfx_d      = b_pfx_q;
    b_prec_d     = b_prec_q;
    b_dig_d      = b_dig_q;
    out_len_d    = out_len_q;
    pos_d        = pos_q;
    strobe_d     = 1'b0;
    char_d       = char_q;
    present_d    = present_q;
    last_d       = last_q;
    len_d        = len_q;
    div_start    = 1'b0;
    div_dividend = mag_in;
    div_divisor  = radix_q;
    stack_ctrl   = '{push: 1'b0, pop: 1'b0, digit: div_rem};
    total        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          nd_d  = '0;
          pos_d = '0;
          if (item_ok) begin
            div_start   = 1'b1;
            div_divisor = radix_i;
            state_d     = S_DIV;
          end else begin
            state_d = S_EMPTY;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          stack_ctrl.push = 1'b1;
          nd_d = nd_q + ND_W'(1);
          if (div_quot == '0) begin
            state_d = S_SIZE1;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end
        end
      end
      S_SIZE1: begin
        prec_eff_d = (prec_u > nd_u) ? prec_u : nd_u;
        rest_d     = REST_W'(width_q) - REST_W'(sign_on_q) - REST_W'(pfx_len_q) -
                     REST_W'(prec_eff_d);
        state_d    = S_SIZE2;
      end
      S_SIZE2: begin
        b_lead_d  = (zero_q || left_q) ? '0 : pad;
        b_sign_d  = b_lead_d + COUNT_W'(sign_on_q);
        b_pfx_d   = b_sign_d + COUNT_W'(pfx_len_q);
        b_prec_d  = b_pfx_d + (zero_q ? pad : '0) + (prec_eff_q - nd_u);
        b_dig_d   = b_prec_d + nd_u;
        total     = b_dig_d + (left_q ? pad : '0);
        out_len_d = (total > COUNT_W'(cap_q)) ? COUNT_W'(cap_q) : total;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        strobe_d  = 1'b1;
        present_d = 1'b1;
        if (pos_q < b_lead_q) begin
          char_d = CH_SPACE;
        end else if (pos_q < b_sign_q) begin
          char_d = sign_ch_q;
        end else if (pos_q < b_pfx_q) begin
          char_d = (pos_q == b_sign_q) ? CH_ZERO : CH_X;
        end else if (pos_q < b_prec_q) begin
          char_d = CH_ZERO;
        end else if (pos_q < b_dig_q) begin
          char_d         = digit_char(stack_top, upper_q);
          stack_ctrl.pop = 1'b1;
        end else begin
          char_d = CH_SPACE;
        end
        pos_d  = pos_q + COUNT_W'(1);
        last_d = (pos_d == out_len_q);
        len_d  = last_d ? out_len_q[LEN_W-1:0] : '0;
        if (last_d) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        strobe_d  = 1'b1;
        present_d = 1'b0;
        char_d    = CH_NUL;
        last_d    = 1'b1;
        len_d     = '0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      nd_q     <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      nd_q     <= nd_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      width_q   <= field_width_i;
      prec_q    <= min_digits_i;
      radix_q   <= radix_i;
      cap_q     <= cap_in;
      upper_q   <= flags_in[FLAG_UPPER];
      zero_q    <= flags_in[FLAG_ZERO];
      left_q    <= flags_in[FLAG_LEFT];
      sign_on_q <= sign_on_in;
      sign_ch_q <= sign_ch_in;
      pfx_len_q <= pfx_len_in;
    end
    prec_eff_q <= prec_eff_d;
    rest_q     <= rest_d;
    b_lead_q   <= b_lead_d;
    b_sign_q   <= b_sign_d;
    b_pfx_q    <= b_pfx_d;
    b_prec_q   <= b_prec_d;
    b_dig_q    <= b_dig_d;
    out_len_q  <= out_len_d;
    char_q     <= char_d;
    present_q  <= present_d;
    last_q     <= last_d;
    len_q      <= len_d;
  end

  assign strobe_o       = strobe_q;
  assign character_o    = char_q;
  assign char_present_o = present_q;
  assign last_o         = last_q;
  assign length_o       = len_q;

  a_len_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> length_o == '0)
    else $error("length given on an item that is not last");

  a_empty_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !char_present_o |-> last_o && length_o == '0)
    else $error("empty item not marked last with zero length");

  a_digits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= ND_W'(DIG_DEPTH))
    else $error("digit stack overrun");

  a_div_done_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the digit loop");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item left the block idle");

endmodule
